// ===== rtl/rthap_pkg.sv =====
package rthap_pkg;

	localparam int unsigned MAX_REGIONS_DEF = 1024;
	localparam int unsigned PAGE_BYTES_DEF = 4096;
	localparam logic [31:0] INIT_HEAP_BYTES = 32'd20000000;
	localparam logic [33:0] NO_LIMIT = 34'h0FFFFFFFF;
	localparam logic [33:0] LIMIT_64K = 34'h000010000;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_FREED     = 3'd1,
		ST_NO_FIT    = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_FREE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BND_NONE = 2'd0,
		BND_PAGE = 2'd1,
		BND_64K  = 2'd2,
		BND_ALT  = 2'd3
	} bnd_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} rtype_t;

	typedef enum logic {
		CFG_HEAP_BASE  = 1'b0,
		CFG_HEAP_BYTES = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] req_size;
		logic [4:0]  align_log2;
		logic [1:0]  boundary_mode;
		logic [31:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [31:0] result_addr;
		logic [31:0] alloc_tag;
		logic [2:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [31:0] size;
		logic        rsv;
		logic [31:0] tag;
	} ent_t;

endpackage

// ===== rtl/rthap_ram.sv =====
module rthap_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/region_table_heap_allocator_unit.sv =====
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_ready | rthap_pkg::req_t
// rsp     | out | rsp_valid/rsp_ready | rthap_pkg::rsp_t
// cfg     | in  | cfg_we              | cfg_idx, cfg_wdata
//
// One transaction at a time. The walk visits each region with a RAM read, then
// an evaluate; a fitting candidate then goes through the boundary check, in page
// mode after the remainder unit. Inserting or removing regions shifts the table
// tail at 1 entry per cycle, then makes up to 3 entry writes.
// Reset: the table holds one free region via an entry-0 override; no clearing pass.
// A waiting response does not block acceptance of the next request.
module region_table_heap_allocator_unit #(
	parameter int unsigned MAX_REGIONS = rthap_pkg::MAX_REGIONS_DEF,
	parameter int unsigned PAGE_BYTES = rthap_pkg::PAGE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rthap_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rthap_pkg::rsp_t rsp,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [31:0]     cfg_wdata
);

	import rthap_pkg::*;

	localparam int unsigned AW = $clog2(MAX_REGIONS);
	localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
	localparam logic [31:0] PAGE_K = 32'(PAGE_BYTES);
	localparam logic [31:0] PAGE_RECIP = 32'((64'd1 << 32) / 64'(PAGE_BYTES));
	localparam logic [CW:0] MAX_C = (CW+1)'(MAX_REGIONS);

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_RD   = 14'b00000000000010,
		S_EV   = 14'b00000000000100,
		S_MOD  = 14'b00000000001000,
		S_BCHK = 14'b00000000010000,
		S_RDN  = 14'b00000000100000,
		S_NX   = 14'b00000001000000,
		S_FC   = 14'b00000010000000,
		S_SH   = 14'b00000100000000,
		S_WR   = 14'b00001000000000,
		S_DONE = 14'b00010000000000,
		S_SP1  = 14'b00100000000000,
		S_SP2  = 14'b01000000000000,
		S_SP3  = 14'b10000000000000
	} state_t;

	state_t      state_q;
	logic [31:0] heap_base_q, heap_bytes_q, tag_q;
	logic [CW-1:0] count_q;
	logic        ovr_q, rd0_q;
	req_t        req_q;
	logic [33:0] size_q, pad_q, aligned_q, rsz_q;
	logic [31:0] addr_q, cur_sz_q, prev_sz_q, ns_q;
	logic        prev_rsv_q, nfree_q;
	logic [AW-1:0] idx_q, k_q, wk_q, lim_q, wpos_q;
	logic        dir_up_q, more_q, pend_q;
	logic [1:0]  off_q, wn_q, wc_q;
	ent_t        wb_q [3];
	logic [31:0] rem_q, quo_q;
	logic [31:0] mbits_q;
	logic [2:0]  mcnt_q;
	rsp_t        res_q, rsp_q;
	logic        rsp_valid_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	ent_t          ram_wdata, ram_rdata, e;

	rthap_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_REGIONS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign e = (rd0_q && ovr_q) ? ent_t'{size: heap_bytes_q, rsv: 1'b0, tag: 32'd0} : ram_rdata;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		ram_raddr = idx_q;
		ram_we = 1'b0;
		ram_waddr = wpos_q;
		ram_wdata = e;
		unique case (state_q)
			S_RDN: ram_raddr = idx_q + AW'(1);
			S_SH: begin
				ram_raddr = k_q;
				ram_we = pend_q;
				ram_waddr = dir_up_q ? wk_q + AW'(off_q) : wk_q - AW'(off_q);
			end
			S_WR: begin
				ram_we = 1'b1;
				ram_waddr = wpos_q + AW'(wc_q);
				ram_wdata = wb_q[wc_q];
			end
			default: ;
		endcase
	end

	logic [33:0] req_rnd;
	assign req_rnd = ({2'b0, req.req_size} + 34'd3) & ~34'd3;

	// walk evaluation
	logic [33:0] alm1, aligned, pad, limv;
	logic [31:0] rem_o;
	logic        fits, last, match;
	always_comb begin
		alm1 = (34'd1 << req_q.align_log2) - 34'd1;
		aligned = ({2'b0, addr_q} + alm1) & ~alm1;
		pad = aligned - {2'b0, addr_q};
		fits = !e.rsv && ({2'b0, e.size} >= size_q + pad);
		last = (CW'(idx_q) + CW'(1)) == count_q;
		match = (addr_q == req_q.free_addr) && e.rsv;
		unique case (bnd_t'(req_q.boundary_mode))
			BND_PAGE: limv = 34'(PAGE_BYTES);
			BND_64K:  limv = LIMIT_64K;
			default:  limv = NO_LIMIT;
		endcase
		unique case (bnd_t'(req_q.boundary_mode))
			BND_64K: rem_o = {16'd0, addr_q[15:0]};
			default: rem_o = (addr_q == 32'hFFFFFFFF) ? 32'd0 : addr_q;
		endcase
	end

	// remainder by the page size: reciprocal estimate is low by at most one
	logic [63:0] mq;
	logic [31:0] qp, rem_fix;
	always_comb begin
		mq = 64'(mbits_q) * 64'(PAGE_RECIP);
		qp = quo_q * PAGE_K;
		rem_fix = (rem_q >= PAGE_K) ? rem_q - PAGE_K : rem_q;
	end

	// allocation commit
	logic        lefto, full;
	logic [1:0]  need;
	logic [31:0] tag_n;
	ent_t        e_pad, e_rsv, e_left;
	always_comb begin
		lefto = (rsz_q - pad_q) > size_q;
		need = {1'b0, pad_q != 34'd0} + {1'b0, lefto};
		full = ({1'b0, count_q} + (CW+1)'(need)) > MAX_C;
		tag_n = tag_q + 32'd1;
		e_pad = '{size: pad_q[31:0], rsv: 1'b0, tag: 32'd0};
		e_rsv = '{size: lefto ? size_q[31:0] : 32'(rsz_q - pad_q), rsv: 1'b1, tag: tag_n};
		e_left = '{size: 32'(rsz_q - pad_q - size_q), rsv: 1'b0, tag: 32'd0};
	end

	// free merge
	logic        pfree;
	logic [1:0]  r;
	logic [31:0] msz;
	logic [CW-1:0] src;
	always_comb begin
		pfree = (idx_q != '0) && !prev_rsv_q;
		r = {1'b0, nfree_q} + {1'b0, pfree};
		msz = cur_sz_q + (nfree_q ? ns_q : 32'd0) + (pfree ? prev_sz_q : 32'd0);
		src = CW'(idx_q) + CW'(1) + CW'(nfree_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			heap_base_q <= '0;
			heap_bytes_q <= INIT_HEAP_BYTES;
			tag_q <= '0;
			count_q <= CW'(1);
			ovr_q <= 1'b1;
			rsp_valid_q <= 1'b0;
			more_q <= 1'b0;
			pend_q <= 1'b0;
			rd0_q <= 1'b0;
		end else begin
			rd0_q <= (ram_raddr == '0);
			if (cfg_we && cfg_idx_t'(cfg_idx) == CFG_HEAP_BYTES) ovr_q <= 1'b1;
			else if (ram_we && ram_waddr == '0) ovr_q <= 1'b0;
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx_t'(cfg_idx) == CFG_HEAP_BASE) begin
					heap_base_q <= cfg_wdata;
				end else begin
					heap_bytes_q <= cfg_wdata;
					count_q <= CW'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						size_q <= req_rnd;
						addr_q <= heap_base_q;
						idx_q <= '0;
						prev_rsv_q <= 1'b1;
						if (rtype_t'(req.req_type) == REQ_FREE && req.free_addr == 32'd0) begin
							res_q <= '{result_addr: 32'd0, alloc_tag: 32'd0, status: ST_FREED};
							state_q <= S_DONE;
						end else if (rtype_t'(req.req_type) == REQ_ALLOC && (
							(bnd_t'(req.boundary_mode) == BND_PAGE &&
							 req_rnd > 34'(PAGE_BYTES)) ||
							(bnd_t'(req.boundary_mode) == BND_64K &&
							 req_rnd > LIMIT_64K))) begin
							res_q <= '{result_addr: 32'd0, alloc_tag: 32'd0, status: ST_NO_FIT};
							state_q <= S_DONE;
						end else begin
							res_q <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (rtype_t'(req_q.req_type) == REQ_ALLOC && fits) begin
						pad_q <= pad;
						aligned_q <= aligned;
						rsz_q <= {2'b0, e.size};
						if (bnd_t'(req_q.boundary_mode) == BND_PAGE) begin
							mbits_q <= addr_q;
							mcnt_q <= '0;
							state_q <= S_MOD;
						end else begin
							rem_q <= rem_o;
							state_q <= S_BCHK;
						end
					end else if (rtype_t'(req_q.req_type) == REQ_FREE && match) begin
						cur_sz_q <= e.size;
						nfree_q <= 1'b0;
						state_q <= last ? S_FC : S_RDN;
					end else begin
						addr_q <= addr_q + e.size;
						prev_rsv_q <= e.rsv;
						prev_sz_q <= e.size;
						if (last) begin
							res_q.status <= (rtype_t'(req_q.req_type) == REQ_FREE) ?
								ST_BAD_FREE : ST_NO_FIT;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_MOD: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd0) begin
						quo_q <= mq[63:32];
					end else if (mcnt_q == 3'd1) begin
						rem_q <= mbits_q - qp;
					end else begin
						rem_q <= rem_fix;
						state_q <= S_BCHK;
					end
				end
				S_BCHK: begin
					if (limv - {2'b0, rem_q} >= pad_q) begin
						if (full) begin
							res_q.status <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							tag_q <= tag_n;
							count_q <= count_q + CW'(need);
							res_q <= '{result_addr: aligned_q[31:0], alloc_tag: tag_n,
								status: ST_ALLOCATED};
							wpos_q <= idx_q;
							if (pad_q != 34'd0) begin
								wb_q[0] <= e_pad;
								wb_q[1] <= e_rsv;
								wb_q[2] <= e_left;
							end else begin
								wb_q[0] <= e_rsv;
								wb_q[1] <= e_left;
								wb_q[2] <= e_left;
							end
							wn_q <= need + 2'd1;
							wc_q <= '0;
							if (need != 2'd0 && count_q > CW'(idx_q) + CW'(1)) begin
								dir_up_q <= 1'b1;
								k_q <= AW'(count_q - CW'(1));
								lim_q <= idx_q + AW'(1);
								off_q <= need;
								more_q <= 1'b1;
								pend_q <= 1'b0;
								state_q <= S_SH;
							end else begin
								state_q <= S_WR;
							end
						end
					end else begin
						addr_q <= addr_q + rsz_q[31:0];
						if (last) begin
							res_q.status <= ST_NO_FIT;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_RDN: state_q <= S_NX;
				S_NX: begin
					nfree_q <= !e.rsv;
					ns_q <= e.size;
					state_q <= S_FC;
				end
				S_FC: begin
					res_q.status <= ST_FREED;
					wb_q[0] <= '{size: msz, rsv: 1'b0, tag: 32'd0};
					wn_q <= 2'd1;
					wc_q <= '0;
					wpos_q <= pfree ? idx_q - AW'(1) : idx_q;
					count_q <= count_q - CW'(r);
					if (r != 2'd0 && src < count_q) begin
						dir_up_q <= 1'b0;
						k_q <= AW'(src);
						lim_q <= AW'(count_q - CW'(1));
						off_q <= r;
						more_q <= 1'b1;
						pend_q <= 1'b0;
						state_q <= S_SH;
					end else begin
						state_q <= S_WR;
					end
				end
				S_SH: begin
					pend_q <= more_q;
					wk_q <= k_q;
					if (more_q) begin
						if (k_q == lim_q) more_q <= 1'b0;
						else k_q <= dir_up_q ? k_q - AW'(1) : k_q + AW'(1);
					end else if (!pend_q) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					wc_q <= wc_q + 2'd1;
					if (wc_q == wn_q - 2'd1) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
